FILE: src/kwm_pkg.sv
`timescale 1ns / 1ps
package kwm_pkg;
   localparam int NUM_ARRAYS = 8;
   localparam int MAX_LEN    = 256;
   localparam int MAX_K      = 64;
   localparam int AID_W      = $clog2(NUM_ARRAYS);
   localparam int IDX_W      = $clog2(MAX_LEN);
   localparam int LEN_W      = IDX_W + 1;
   localparam int ADDR_W     = AID_W + IDX_W;
   localparam int HPOS_W     = $clog2(NUM_ARRAYS);
   localparam int HCNT_W     = HPOS_W + 1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;
   localparam logic CSR_TOP_K  = 1'b0;
   localparam logic CSR_ARRAYS = 1'b1;

   typedef struct packed {
      logic signed [31:0] val;
      logic [AID_W-1:0]   arr;
      logic [IDX_W-1:0]   idx;
   } hentry_type;

   // element store request from the sequencer
   typedef struct packed {
      logic              rd;
      logic [ADDR_W-1:0] addr;
   } erd_type;
endpackage

FILE: src/kway_merge_top_k_unit.sv
`timescale 1ns / 1ps
// Channel | Ports                                  | Direction
// request | start/busy, req_command,array_id,value   | in, taken when start & !busy
// result  | rsp_valid, value_res,rank,last,empty   | out, one-cycle strobe
// config  | csr_we, csr_index, csr_data           | in, write on csr_we
// A load leaves busy low, so loads can follow back to back.
// A run seeds the heap with the last element of each array in use and sifts
// each new entry up, then emits results one by one, sifting the root down
// after each (at most log2 of the heap size swaps), paced by the single
// element-store read port and the heap sift loop.
// Synchronous reset clears lengths and control; stores stay unset.
// The receiver cannot stall; each result is strobed for exactly one cycle.
module kway_merge_top_k_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_command,
   input  logic [2:0]          req_array_id,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_value_res,
   output logic [5:0]          rsp_rank,
   output logic                rsp_last,
   output logic                rsp_empty_res,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [6:0]          csr_data
);
   localparam int AW = kwm_pkg::AID_W;
   localparam int IW = kwm_pkg::IDX_W;
   localparam int LW = kwm_pkg::LEN_W;
   localparam int PW = kwm_pkg::HPOS_W;
   localparam int CW = kwm_pkg::HCNT_W;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SEED  = 9'b000000010,
      S_SEEDW = 9'b000000100,
      S_SUP   = 9'b000001000,
      S_EMIT  = 9'b000010000,
      S_NEXTW = 9'b000100000,
      S_SDN   = 9'b001000000,
      S_SWAP  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [6:0] top_k_ff;
   logic [3:0] arrays_ff;
   logic [LW-1:0] len_ff [kwm_pkg::NUM_ARRAYS];
   kwm_pkg::hentry_type heap_ff [kwm_pkg::NUM_ARRAYS];
   logic [CW-1:0] cnt_ff;
   logic [AW:0]   scan_ff;
   logic [PW-1:0] pos_ff;
   logic [6:0]    n_ff, k_lim;
   logic [AW:0]   rows;
   logic signed [31:0] rdata;
   kwm_pkg::erd_type rreq;

   // clamped run parameters
   always_comb begin
      k_lim = (top_k_ff == 7'd0) ? 7'd1 :
              (top_k_ff > 7'(kwm_pkg::MAX_K)) ? 7'(kwm_pkg::MAX_K) : top_k_ff;
      rows = (arrays_ff > 4'(kwm_pkg::NUM_ARRAYS)) ? (AW+1)'(kwm_pkg::NUM_ARRAYS)
                                                  : (AW+1)'(arrays_ff);
   end

   wire load_go = start && !busy && req_command == kwm_pkg::CMD_LOAD;
   wire run_go  = start && !busy && req_command == kwm_pkg::CMD_RUN;
   wire [AW-1:0] scan_a = scan_ff[AW-1:0];
   wire load_ok = len_ff[req_array_id[AW-1:0]] < LW'(kwm_pkg::MAX_LEN);

   kwm_elem_ram u_ram (
      .clock(clock), .we(load_go && load_ok),
      .waddr({req_array_id[AW-1:0], len_ff[req_array_id[AW-1:0]][IW-1:0]}),
      .wdata(req_value), .rreq(rreq), .rdata(rdata));

   // sift helpers; child positions two bits wider so the right child of the
   // last slot does not wrap back to the root
   logic [PW:0]   par;
   logic [PW+1:0] lc, rc, best;
   kwm_pkg::hentry_type top;
   always_comb begin
      top  = heap_ff[0];
      par  = (PW+1)'((pos_ff - 1'b1) >> 1);
      lc   = {1'b0, pos_ff, 1'b1};
      rc   = lc + 1'b1;
      best = (PW+2)'(pos_ff);
      if (lc < (PW+2)'(cnt_ff) && heap_ff[lc[PW-1:0]].val > heap_ff[pos_ff].val)
         best = lc;
      if (rc < (PW+2)'(cnt_ff) && heap_ff[rc[PW-1:0]].val > heap_ff[best[PW-1:0]].val)
         best = rc;
   end

   always_comb begin
      rreq.rd = 1'b0;
      rreq.addr = '0;
      case (state_ff)
         S_SEED: begin
            rreq.rd = 1'b1;
            rreq.addr = {scan_a, IW'(len_ff[scan_a] - 1'b1)};
         end
         S_EMIT: begin
            rreq.rd = 1'b1;
            rreq.addr = {top.arr, IW'(top.idx - 1'b1)};
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (run_go) state_in = S_SEED;
         S_SEED:  if (scan_ff >= rows) state_in = (cnt_ff == '0) ? S_DONE : S_EMIT;
                  else if (len_ff[scan_a] != '0) state_in = S_SEEDW;
         S_SEEDW: state_in = S_SUP;
         S_SUP:   if (pos_ff == '0 || heap_ff[par[PW-1:0]].val >= heap_ff[pos_ff].val)
                     state_in = S_SEED;
         S_EMIT:  state_in = S_NEXTW;
         S_NEXTW: state_in = S_SDN;
         S_SDN:   if (cnt_ff == '0 || n_ff >= k_lim) state_in = S_IDLE;
                  else if (best[PW-1:0] == pos_ff || best > (PW+2)'(cnt_ff))
                     state_in = S_EMIT;
                  else state_in = S_SWAP;
         S_SWAP:  state_in = S_SDN;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = state_ff != S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         top_k_ff  <= 7'd5;
         arrays_ff <= 4'd8;
         cnt_ff    <= '0;
         rsp_valid <= 1'b0;
         for (int i = 0; i < kwm_pkg::NUM_ARRAYS; i++) len_ff[i] <= '0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= 1'b0;
         if (csr_we) begin
            if (csr_index == kwm_pkg::CSR_TOP_K) top_k_ff <= csr_data;
            else arrays_ff <= csr_data[3:0];
         end
         if (load_go && load_ok)
            len_ff[req_array_id[AW-1:0]] <= len_ff[req_array_id[AW-1:0]] + 1'b1;
         case (state_ff)
            S_IDLE: if (run_go) begin
               cnt_ff <= '0; scan_ff <= '0; n_ff <= '0;
            end
            S_SEED: if (scan_ff < rows && len_ff[scan_a] == '0) scan_ff <= scan_ff + 1'b1;
            else if (scan_ff >= rows) pos_ff <= '0;
            S_SEEDW: begin
               heap_ff[cnt_ff[PW-1:0]] <= '{rdata, scan_a, IW'(len_ff[scan_a] - 1'b1)};
               pos_ff  <= cnt_ff[PW-1:0];
               cnt_ff  <= cnt_ff + 1'b1;
               scan_ff <= scan_ff + 1'b1;
            end
            S_SUP: if (!(pos_ff == '0 ||
                         heap_ff[par[PW-1:0]].val >= heap_ff[pos_ff].val)) begin
               heap_ff[par[PW-1:0]] <= heap_ff[pos_ff];
               heap_ff[pos_ff]      <= heap_ff[par[PW-1:0]];
               pos_ff <= par[PW-1:0];
            end else pos_ff <= '0;
            S_EMIT: begin
               rsp_valid     <= 1'b1;
               rsp_value_res <= top.val;
               rsp_rank      <= n_ff[5:0];
               rsp_empty_res <= 1'b0;
               rsp_last      <= (n_ff + 1'b1 >= k_lim) ||
                                (cnt_ff == CW'(1) && top.idx == '0);
               n_ff <= n_ff + 1'b1;
            end
            S_NEXTW: begin
               pos_ff <= '0;
               if (top.idx != '0) heap_ff[0] <= '{rdata, top.arr, top.idx - 1'b1};
               else begin
                  heap_ff[0] <= heap_ff[PW'(cnt_ff - 1'b1)];
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            S_SWAP: begin
               heap_ff[best[PW-1:0]] <= heap_ff[pos_ff];
               heap_ff[pos_ff]       <= heap_ff[best[PW-1:0]];
               pos_ff <= best[PW-1:0];
            end
            S_DONE: begin
               rsp_valid <= 1'b1; rsp_value_res <= '0; rsp_rank <= '0;
               rsp_last <= 1'b1; rsp_empty_res <= 1'b1;
            end
            default: ;
         endcase
         // a run clears every length once seeded
         if (state_ff == S_SEED && scan_ff >= rows)
            for (int i = 0; i < kwm_pkg::NUM_ARRAYS; i++) len_ff[i] <= '0;
      end
   end
endmodule

FILE: src/kwm_elem_ram.sv
`timescale 1ns / 1ps
module kwm_elem_ram (
   input  logic                        clock,
   input  logic                        we,
   input  logic [kwm_pkg::ADDR_W-1:0]  waddr,
   input  logic signed [31:0]          wdata,
   input  kwm_pkg::erd_type            rreq,
   output logic signed [31:0]          rdata
);
   logic signed [31:0] mem [2**kwm_pkg::ADDR_W];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (rreq.rd) rdata <= mem[rreq.addr];
   end
endmodule

FILE: src/kwm_checker.sv
`timescale 1ns / 1ps
module kwm_assert_checker (
   input logic clock, reset, busy, rsp_valid, rsp_last, rsp_empty_res,
   input logic [5:0] rsp_rank
);
   // results only while a run is in progress
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result outside run");
   // empty result is rank 0 and last
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && rsp_rank == 6'd0)
      else $error("bad empty result");
   // no result straight after a final one
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid) else $error("result after last");
endmodule

bind kway_merge_top_k_unit kwm_assert_checker u_chk (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_last(rsp_last), .rsp_empty_res(rsp_empty_res),
   .rsp_rank(rsp_rank));
